@@ sv/assert_macros.svh @@
// Assertion macros shared by the checker files.
// Each macro checks on the rising edge of clk and is switched off while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Overlapping or next-cycle implication, clocked on clk, off during reset.
`define ASSERT_CLKD(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Plain implication wrapper that reads well at the use site.
`define ASSERT_IMPLIES(label, lhs, rhs, msg) \
	`ASSERT_CLKD(label, (lhs) |-> (rhs), msg)

`endif

@@ sv/fxalu_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fxalu_pkg
// Shared constants, operation codes and bundle types of the Q24.8 fixed-point
// ALU pipeline.
// ----------------------------------------------------------------------------
package fxalu_pkg;

	localparam int FRACTION_BITS = 8;
	localparam int WORD_W        = 32;
	// Dividend is the operand magnitude shifted up by the fraction bits
	localparam int DIV_W         = WORD_W + FRACTION_BITS;
	localparam int DIV_STEPS     = DIV_W;
	// Exponent offset for single to fixed: shift = exp - 150 + fraction bits
	localparam int SH_BIAS       = 150 - FRACTION_BITS;
	// Biased exponent offset for fixed to single
	localparam int EXP_OFFSET    = 127 - FRACTION_BITS;
	localparam int SAT_SHIFT     = 40;
	localparam int FLUSH_SHIFT   = 26;

	localparam logic [WORD_W-1:0] MAX_POS = 32'h7FFF_FFFF;
	localparam logic [WORD_W-1:0] MIN_NEG = 32'h8000_0000;

	typedef enum logic [3:0] {
		FN_INT2FIX   = 4'd0,
		FN_FLOAT2FIX = 4'd1,
		FN_TOFLOAT   = 4'd2,
		FN_TOINT     = 4'd3,
		FN_ADD       = 4'd4,
		FN_SUB       = 4'd5,
		FN_MUL       = 4'd6,
		FN_DIV       = 4'd7,
		FN_CMP       = 4'd8,
		FN_MIN       = 4'd9,
		FN_MAX       = 4'd10,
		FN_INC       = 4'd11,
		FN_DEC       = 4'd12
	} func_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] result_value;
		logic [WORD_W-1:0]        float_result;
		logic                     greater;
		logic                     less;
		logic                     equal;
		logic                     range_error;
	} res_t;

	typedef struct packed {
		logic              is_div;
		logic              zero;
		logic              neg;
		logic [WORD_W-1:0] mag_a;
		logic [WORD_W-1:0] mag_b;
	} div_op_t;

endpackage

@@ sv/fxalu_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fxalu_front
// Four register stages that compute every operation except divide, and
// prepare the divide operand magnitudes for the divider pipeline.
// ----------------------------------------------------------------------------
module fxalu_front import fxalu_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     in_valid,
	input  logic [3:0]               func,
	input  logic signed [WORD_W-1:0] operand_a,
	input  logic signed [WORD_W-1:0] operand_b,
	input  logic [WORD_W-1:0]        float_bits,
	output logic                     out_valid,
	output res_t                     out_res,
	output div_op_t                  out_div
);

	// stage 1 registers
	logic                     v_s1;
	func_t                    fn_s1;
	res_t                     simple_s1;
	logic signed [63:0]       prod_s1;
	logic                     tf_sign_s1;
	logic [WORD_W-1:0]        tf_abs_s1;
	logic                     ff_sign_s1;
	logic                     ff_special_s1;
	logic                     ff_nan_s1;
	logic [23:0]              ff_man_s1;
	logic signed [9:0]        ff_sh_s1;
	div_op_t                  div_s1;

	// stage 2 registers
	logic                     v_s2;
	func_t                    fn_s2;
	res_t                     simple_s2;
	logic [WORD_W-1:0]        mul_s2;
	logic                     tf_sign_s2;
	logic                     tf_zero_s2;
	logic [WORD_W-1:0]        tf_abs_s2;
	logic [4:0]               tf_pos_s2;
	logic                     ff_sign_s2;
	logic                     ff_special_s2;
	logic                     ff_nan_s2;
	logic                     ff_over_s2;
	logic [63:0]              ff_mag_s2;
	logic                     ff_rb_s2;
	div_op_t                  div_s2;

	// stage 3 registers
	logic                     v_s3;
	func_t                    fn_s3;
	res_t                     simple_s3;
	logic [WORD_W-1:0]        mul_s3;
	logic                     tf_sign_s3;
	logic                     tf_zero_s3;
	logic [WORD_W-1:0]        tf_norm_s3;
	logic [4:0]               tf_pos_s3;
	logic                     ff_sign_s3;
	logic                     ff_special_s3;
	logic                     ff_nan_s3;
	logic                     ff_over_s3;
	logic [63:0]              ff_mag_s3;
	div_op_t                  div_s3;

	// stage 4 registers
	logic                     v_s4;
	res_t                     res_s4;
	div_op_t                  div_s4;

	// stage 1 combinational
	func_t                    fn_in;
	res_t                     simple_c;
	logic [7:0]               ex_c;
	logic [7:0]               exu_c;
	logic signed [9:0]        sh_c;
	div_op_t                  div_c;

	always_comb begin
		fn_in = func_t'(func);
		simple_c = '0;
		unique case (fn_in)
			FN_INT2FIX: simple_c.result_value = operand_a <<< FRACTION_BITS;
			FN_TOINT:   simple_c.result_value = operand_a >>> FRACTION_BITS;
			FN_ADD:     simple_c.result_value = operand_a + operand_b;
			FN_SUB:     simple_c.result_value = operand_a - operand_b;
			FN_CMP: begin
				simple_c.greater = operand_a > operand_b;
				simple_c.less    = operand_a < operand_b;
				simple_c.equal   = operand_a == operand_b;
			end
			FN_MIN:     simple_c.result_value = (operand_a < operand_b) ? operand_a : operand_b;
			FN_MAX:     simple_c.result_value = (operand_a > operand_b) ? operand_a : operand_b;
			FN_INC:     simple_c.result_value = operand_a + 32'sd1;
			FN_DEC:     simple_c.result_value = operand_a - 32'sd1;
			default:    simple_c = '0;
		endcase

		// decode the single-precision pattern
		ex_c  = float_bits[30:23];
		exu_c = (ex_c == 8'd0) ? 8'd1 : ex_c;
		sh_c  = $signed({2'b00, exu_c}) - $signed(10'(SH_BIAS));

		// divide operands as magnitudes
		div_c.is_div = (fn_in == FN_DIV);
		div_c.zero   = (operand_b == '0);
		div_c.neg    = operand_a[WORD_W-1] ^ operand_b[WORD_W-1];
		div_c.mag_a  = operand_a[WORD_W-1] ? (32'd0 - operand_a) : operand_a;
		div_c.mag_b  = operand_b[WORD_W-1] ? (32'd0 - operand_b) : operand_b;
	end

	// stage 2 combinational
	logic [4:0]  pos_c;
	logic [9:0]  k_c;
	logic [4:0]  kk_c;
	logic [24:0] rtmp_c;
	logic [63:0] mag_pre_c;
	logic        rb_c;
	logic        over_c;

	always_comb begin
		// leading one position of the tofloat magnitude
		pos_c = '0;
		for (int i = 0; i < WORD_W; i++) begin
			if (tf_abs_s1[i])
				pos_c = 5'(i);
		end

		// align the float mantissa to the fixed-point grid
		k_c       = 10'd0 - ff_sh_s1;
		kk_c      = k_c[4:0];
		rtmp_c    = '0;
		mag_pre_c = '0;
		rb_c      = 1'b0;
		over_c    = 1'b0;
		if (ff_sh_s1 >= 10'sd40) begin
			over_c = 1'b1;
		end else if (ff_sh_s1 >= 10'sd0) begin
			mag_pre_c = {40'd0, ff_man_s1} << ff_sh_s1[5:0];
		end else if (k_c < 10'(FLUSH_SHIFT)) begin
			mag_pre_c = {40'd0, ff_man_s1 >> kk_c};
			rtmp_c    = {1'b0, ff_man_s1} >> (kk_c - 5'd1);
			rb_c      = rtmp_c[0];
		end
	end

	// stage 4 combinational
	res_t        res_c;
	logic [7:0]  bexp_c;
	logic        rnd_c;
	logic [30:0] packed_c;

	always_comb begin
		bexp_c   = 8'(tf_pos_s3) + 8'(EXP_OFFSET);
		rnd_c    = tf_norm_s3[7] & ((|tf_norm_s3[6:0]) | tf_norm_s3[8]);
		packed_c = {bexp_c, tf_norm_s3[30:8]} + 31'(rnd_c);

		res_c = simple_s3;
		unique case (fn_s3)
			FN_FLOAT2FIX: begin
				res_c = '0;
				if (ff_special_s3) begin
					res_c.range_error  = 1'b1;
					res_c.result_value = ff_nan_s3 ? '0 : (ff_sign_s3 ? MIN_NEG : MAX_POS);
				end else if (ff_over_s3) begin
					res_c.range_error  = 1'b1;
					res_c.result_value = ff_sign_s3 ? MIN_NEG : MAX_POS;
				end else if (ff_sign_s3) begin
					if (ff_mag_s3 > {32'd0, MIN_NEG}) begin
						res_c.range_error  = 1'b1;
						res_c.result_value = MIN_NEG;
					end else begin
						res_c.result_value = 32'd0 - ff_mag_s3[WORD_W-1:0];
					end
				end else begin
					if (ff_mag_s3 > {32'd0, MAX_POS}) begin
						res_c.range_error  = 1'b1;
						res_c.result_value = MAX_POS;
					end else begin
						res_c.result_value = ff_mag_s3[WORD_W-1:0];
					end
				end
			end
			FN_TOFLOAT: begin
				res_c = '0;
				res_c.float_result = tf_zero_s3 ? '0 : {tf_sign_s3, packed_c};
			end
			FN_MUL: begin
				res_c = '0;
				res_c.result_value = mul_s3;
			end
			default: res_c = simple_s3;
		endcase
	end

	// advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// advance payload
	always_ff @(posedge clk) begin
		if (en) begin
			fn_s1         <= fn_in;
			simple_s1     <= simple_c;
			prod_s1       <= 64'(operand_a) * 64'(operand_b);
			tf_sign_s1    <= operand_a[WORD_W-1];
			tf_abs_s1     <= operand_a[WORD_W-1] ? (32'd0 - operand_a) : operand_a;
			ff_sign_s1    <= float_bits[31];
			ff_special_s1 <= (ex_c == 8'hFF);
			ff_nan_s1     <= (float_bits[22:0] != '0);
			ff_man_s1     <= {ex_c != 8'd0, float_bits[22:0]};
			ff_sh_s1      <= sh_c;
			div_s1        <= div_c;

			fn_s2         <= fn_s1;
			simple_s2     <= simple_s1;
			mul_s2        <= 32'(prod_s1 >>> FRACTION_BITS);
			tf_sign_s2    <= tf_sign_s1;
			tf_zero_s2    <= (tf_abs_s1 == '0);
			tf_abs_s2     <= tf_abs_s1;
			tf_pos_s2     <= pos_c;
			ff_sign_s2    <= ff_sign_s1;
			ff_special_s2 <= ff_special_s1;
			ff_nan_s2     <= ff_nan_s1;
			ff_over_s2    <= over_c;
			ff_mag_s2     <= mag_pre_c;
			ff_rb_s2      <= rb_c;
			div_s2        <= div_s1;

			fn_s3         <= fn_s2;
			simple_s3     <= simple_s2;
			mul_s3        <= mul_s2;
			tf_sign_s3    <= tf_sign_s2;
			tf_zero_s3    <= tf_zero_s2;
			tf_norm_s3    <= tf_abs_s2 << (5'd31 - tf_pos_s2);
			tf_pos_s3     <= tf_pos_s2;
			ff_sign_s3    <= ff_sign_s2;
			ff_special_s3 <= ff_special_s2;
			ff_nan_s3     <= ff_nan_s2;
			ff_over_s3    <= ff_over_s2;
			ff_mag_s3     <= ff_mag_s2 + 64'(ff_rb_s2);
			div_s3        <= div_s2;

			res_s4        <= res_c;
			div_s4        <= div_s3;
		end
	end

	assign out_valid = v_s4;
	assign out_res   = res_s4;
	assign out_div   = div_s4;

endmodule

@@ sv/fxalu_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fxalu_div
// Restoring divider, one quotient bit per register stage, followed by a
// sign and divide-by-zero fix-up stage. Results of other operations ride
// along unchanged.
// ----------------------------------------------------------------------------
module fxalu_div import fxalu_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    en,
	input  logic    in_valid,
	input  res_t    in_res,
	input  div_op_t in_div,
	output logic    out_valid,
	output res_t    out_res
);

	typedef struct packed {
		logic              is_div;
		logic              zero;
		logic              neg;
		logic [WORD_W-1:0] mag_b;
		logic [WORD_W-1:0] rem;
		logic [DIV_W-1:0]  dq;
		res_t              res;
	} step_t;

	// index 0 is the stage input, index i the register after step i
	logic  v_s    [DIV_STEPS+1];
	step_t step_s [DIV_STEPS+1];
	logic  v_fin_s;
	res_t  res_fin_s;

	always_comb begin
		v_s[0]           = in_valid;
		step_s[0].is_div = in_div.is_div;
		step_s[0].zero   = in_div.zero;
		step_s[0].neg    = in_div.neg;
		step_s[0].mag_b  = in_div.mag_b;
		step_s[0].rem    = '0;
		step_s[0].dq     = {in_div.mag_a, {FRACTION_BITS{1'b0}}};
		step_s[0].res    = in_res;
	end

	for (genvar i = 0; i < DIV_STEPS; i++) begin : g_step
		logic [WORD_W:0] trial;
		logic            take;
		step_t           nxt;

		// shift in the next dividend bit, subtract when it fits
		always_comb begin
			trial = {step_s[i].rem, step_s[i].dq[DIV_W-1]};
			take  = trial >= {1'b0, step_s[i].mag_b};
			nxt   = step_s[i];
			nxt.rem = take ? 32'(trial - {1'b0, step_s[i].mag_b}) : trial[WORD_W-1:0];
			nxt.dq  = {step_s[i].dq[DIV_W-2:0], take};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else if (en) begin
				v_s[i+1] <= v_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				step_s[i+1] <= nxt;
			end
		end
	end

	// apply sign, flag divide by zero
	res_t  fin_c;
	step_t last_c;

	always_comb begin
		last_c = step_s[DIV_STEPS];
		fin_c  = last_c.res;
		if (last_c.is_div) begin
			fin_c = '0;
			if (last_c.zero) begin
				fin_c.range_error = 1'b1;
			end else begin
				fin_c.result_value = last_c.neg ? (32'd0 - last_c.dq[WORD_W-1:0])
				                                : last_c.dq[WORD_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_fin_s <= 1'b0;
		end else if (en) begin
			v_fin_s <= v_s[DIV_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_fin_s <= fin_c;
		end
	end

	assign out_valid = v_fin_s;
	assign out_res   = res_fin_s;

endmodule

@@ sv/fixed_point_q24_8_alu_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_point_q24_8_alu_top
// Pipelined Q24.8 fixed-point ALU with one result per item.
// ----------------------------------------------------------------------------
// Usage:
//   The item channel (item_valid / item_stall) carries func, operand_a,
//   operand_b and float_bits. An item transfers on a rising edge with
//   item_valid high and item_stall low.
//   The result channel (result_valid / result_stall) carries result_value,
//   float_result, greater, less, equal and range_error, one transfer per item,
//   in input order.
//   The path is 45 register stages: four stages of conversion and arithmetic,
//   40 divider stages (one quotient bit each) and one divide fix-up stage.
//   Every operation takes the same path.
//   Throughput is one item per cycle while the receiver keeps up.
//   When the receiver stalls, the waiting result is parked in a skid register
//   and the pipeline freezes while that register is full; item_stall is high
//   exactly while the skid register is full.
//   Reset clears all valid bits and the skid register; nothing is in flight.
// ----------------------------------------------------------------------------
module fixed_point_q24_8_alu_top import fxalu_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     item_valid,
	output logic                     item_stall,
	input  logic [3:0]               func,
	input  logic signed [WORD_W-1:0] operand_a,
	input  logic signed [WORD_W-1:0] operand_b,
	input  logic [WORD_W-1:0]        float_bits,
	output logic                     result_valid,
	input  logic                     result_stall,
	output logic signed [WORD_W-1:0] result_value,
	output logic [WORD_W-1:0]        float_result,
	output logic                     greater,
	output logic                     less,
	output logic                     equal,
	output logic                     range_error
);

	logic    en;
	logic    front_valid;
	res_t    front_res;
	div_op_t front_div;
	logic    pipe_valid;
	res_t    pipe_res;
	logic    skid_full_q;
	res_t    skid_q;
	res_t    out_res;

	assign en = !skid_full_q;

	fxalu_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.in_valid   (item_valid),
		.func       (func),
		.operand_a  (operand_a),
		.operand_b  (operand_b),
		.float_bits (float_bits),
		.out_valid  (front_valid),
		.out_res    (front_res),
		.out_div    (front_div)
	);

	fxalu_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (front_valid),
		.in_res    (front_res),
		.in_div    (front_div),
		.out_valid (pipe_valid),
		.out_res   (pipe_res)
	);

	// park a stalled result, release it on the next transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_full_q <= 1'b0;
		end else if (skid_full_q) begin
			if (!result_stall)
				skid_full_q <= 1'b0;
		end else if (pipe_valid && result_stall) begin
			skid_full_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!skid_full_q && pipe_valid && result_stall) begin
			skid_q <= pipe_res;
		end
	end

	assign out_res      = skid_full_q ? skid_q : pipe_res;
	assign item_stall   = skid_full_q;
	assign result_valid = skid_full_q | pipe_valid;
	assign result_value = out_res.result_value;
	assign float_result = out_res.float_result;
	assign greater      = out_res.greater;
	assign less         = out_res.less;
	assign equal        = out_res.equal;
	assign range_error  = out_res.range_error;

endmodule

@@ sv/fxalu_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fxalu_checker
// Port-level checks of the fixed-point ALU, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fxalu_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        item_valid,
	input logic        item_stall,
	input logic [3:0]  func,
	input logic [31:0] operand_a,
	input logic [31:0] operand_b,
	input logic [31:0] float_bits,
	input logic        result_valid,
	input logic        result_stall,
	input logic [31:0] result_value,
	input logic [31:0] float_result,
	input logic        greater,
	input logic        less,
	input logic        equal,
	input logic        range_error
);

	// a stalled result stays offered
	`ASSERT_CLKD(a_hold_valid, result_valid && result_stall |=> result_valid, "result dropped while stalled")

	// a stalled result keeps its value
	`ASSERT_CLKD(a_hold_data, result_valid && result_stall |=> $stable(result_value) && $stable(float_result), "result changed while stalled")

	// input back-pressure only while a result is waiting
	`ASSERT_IMPLIES(a_stall_has_result, item_stall, result_valid, "item stalled with no result pending")

	// compare flags never come with an error, and at most one is set
	`ASSERT_IMPLIES(a_flags_excl, result_valid && (greater || less || equal), !range_error && $onehot({greater, less, equal}) && result_value == 32'd0, "bad compare flags")

	// a float result comes with no fixed result and no error
	`ASSERT_IMPLIES(a_float_alone, result_valid && float_result != 32'd0, result_value == 32'd0 && !range_error, "float result mixed with other fields")

endmodule

bind fixed_point_q24_8_alu_top fxalu_checker u_fxalu_checker (.*);

@@ sim/tb_fixed_point_q24_8_alu_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fixed_point_q24_8_alu_top
// Self-checking bench for the Q24.8 fixed-point ALU. A directed set covers
// the conversion corners, rounding ties, saturation, divide by zero and every
// operation; random items follow. Each accepted item is predicted at transfer
// and checked field by field against the result stream, in order, under
// bursty input traffic and a stalling receiver with one long hold.
// ----------------------------------------------------------------------------
module tb_fixed_point_q24_8_alu_top;
	import fxalu_pkg::*;

	localparam int RANDOM_ITEMS = 930;
	localparam int IDLE_LIMIT   = 3000;
	localparam int DRAIN_CYCLES = 60;
	localparam int LONG_HOLD    = 300;

	typedef struct {
		logic [3:0]  fn;
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] fb;
	} alu_item_t;

	// Expected-result store with the Q24.8 arithmetic predictor
	class alu_scoreboard;
		res_t expected_q[$];
		int   errors;
		int   checked;
		int   per_op[16];

		function logic [31:0] single_to_q(input logic [31:0] fb, output logic err);
			logic [7:0]  ex;
			logic [63:0] man;
			logic [63:0] mag;
			int          sh;
			int          k;
			err = 1'b0;
			ex  = fb[30:23];
			man = {41'd0, fb[22:0]};
			if (ex == 8'hFF) begin
				err = 1'b1;
				if (man != 0)
					return 32'd0;
				return fb[31] ? MIN_NEG : MAX_POS;
			end
			if (ex != 0)
				man[23] = 1'b1;
			else
				ex = 8'd1;
			if (man == 0)
				return 32'd0;
			sh = int'(ex) - 150 + FRACTION_BITS;
			if (sh >= 40) begin
				err = 1'b1;
				return fb[31] ? MIN_NEG : MAX_POS;
			end
			if (sh >= 0) begin
				mag = man << sh;
			end else begin
				k = -sh;
				if (k >= 26)
					return 32'd0;
				mag = (man >> k) + ((man >> (k - 1)) & 64'd1);
			end
			if (fb[31]) begin
				if (mag > 64'h8000_0000) begin
					err = 1'b1;
					return MIN_NEG;
				end
				return 32'd0 - mag[31:0];
			end
			if (mag > 64'h7FFF_FFFF) begin
				err = 1'b1;
				return MAX_POS;
			end
			return mag[31:0];
		endfunction

		function logic [31:0] q_to_single(input logic [31:0] raw);
			logic [31:0] m;
			logic [31:0] man;
			logic [31:0] rem;
			logic [31:0] half;
			logic [7:0]  bexp;
			int          p;
			int          r;
			m = raw[31] ? (32'd0 - raw) : raw;
			if (m == 0)
				return 32'd0;
			p = 31;
			while (m[p] == 1'b0)
				p--;
			bexp = 8'(p - FRACTION_BITS + 127);
			if (p <= 23) begin
				man = m << (23 - p);
			end else begin
				r    = p - 23;
				rem  = m & ((32'd1 << r) - 32'd1);
				half = 32'd1 << (r - 1);
				man  = m >> r;
				if (rem > half || (rem == half && man[0]))
					man++;
				if (man >> 24) begin
					man  = man >> 1;
					bexp = bexp + 8'd1;
				end
			end
			return {raw[31], bexp, man[22:0]};
		endfunction

		function logic [31:0] q_divide(input logic [31:0] a, input logic [31:0] b);
			longint      na;
			longint      nb;
			logic [63:0] ma;
			logic [63:0] mb;
			logic [63:0] q;
			na = longint'($signed(a));
			nb = longint'($signed(b));
			ma = na < 0 ? 64'(-na) : 64'(na);
			mb = nb < 0 ? 64'(-nb) : 64'(nb);
			q  = (ma << FRACTION_BITS) / mb;
			if ((na < 0) != (nb < 0))
				q = 64'd0 - q;
			return q[31:0];
		endfunction

		function res_t predict_alu(input alu_item_t it);
			res_t   r;
			longint sa;
			longint sb;
			longint prod;
			logic   err;
			r  = '0;
			sa = longint'($signed(it.a));
			sb = longint'($signed(it.b));
			case (it.fn)
				FN_INT2FIX: r.result_value = it.a << FRACTION_BITS;
				FN_FLOAT2FIX: begin
					r.result_value = single_to_q(it.fb, err);
					r.range_error  = err;
				end
				FN_TOFLOAT: r.float_result = q_to_single(it.a);
				FN_TOINT: r.result_value = 32'(sa >>> FRACTION_BITS);
				FN_ADD: r.result_value = it.a + it.b;
				FN_SUB: r.result_value = it.a - it.b;
				FN_MUL: begin
					prod = sa * sb;
					r.result_value = 32'(prod >>> FRACTION_BITS);
				end
				FN_DIV: begin
					if (it.b == 0)
						r.range_error = 1'b1;
					else
						r.result_value = q_divide(it.a, it.b);
				end
				FN_CMP: begin
					r.greater = sa > sb;
					r.less    = sa < sb;
					r.equal   = sa == sb;
				end
				FN_MIN: r.result_value = sa < sb ? it.a : it.b;
				FN_MAX: r.result_value = sa > sb ? it.a : it.b;
				FN_INC: r.result_value = it.a + 32'd1;
				FN_DEC: r.result_value = it.a - 32'd1;
				default: r = '0;
			endcase
			return r;
		endfunction

		function void note_item(input alu_item_t it);
			expected_q.push_back(predict_alu(it));
			per_op[it.fn]++;
		endfunction

		function void check_result(input res_t got);
			res_t e;
			if (expected_q.size() == 0) begin
				$error("result with no pending item: value %h", got.result_value);
				errors++;
				return;
			end
			e = expected_q.pop_front();
			checked++;
			if (got.result_value !== e.result_value) begin
				$error("result_value: expected %h, got %h", e.result_value, got.result_value);
				errors++;
			end
			if (got.float_result !== e.float_result) begin
				$error("float_result: expected %h, got %h", e.float_result, got.float_result);
				errors++;
			end
			if (got.greater !== e.greater) begin
				$error("greater: expected %b, got %b", e.greater, got.greater);
				errors++;
			end
			if (got.less !== e.less) begin
				$error("less: expected %b, got %b", e.less, got.less);
				errors++;
			end
			if (got.equal !== e.equal) begin
				$error("equal: expected %b, got %b", e.equal, got.equal);
				errors++;
			end
			if (got.range_error !== e.range_error) begin
				$error("range_error: expected %b, got %b", e.range_error, got.range_error);
				errors++;
			end
		endfunction
	endclass

	logic                     clk;
	logic                     arst_n;
	logic                     item_valid;
	logic                     item_stall;
	logic [3:0]               func;
	logic signed [WORD_W-1:0] operand_a;
	logic signed [WORD_W-1:0] operand_b;
	logic [WORD_W-1:0]        float_bits;
	logic                     result_valid;
	logic                     result_stall;
	logic signed [WORD_W-1:0] result_value;
	logic [WORD_W-1:0]        float_result;
	logic                     greater;
	logic                     less;
	logic                     equal;
	logic                     range_error;

	alu_scoreboard alu_sb;
	alu_item_t     stim_q[$];
	int            idle_cycles;
	int            cycle_count;
	int            hold_left;
	bit            hold_done;

	fixed_point_q24_8_alu_top dut (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_stall(item_stall),
		.func(func), .operand_a(operand_a), .operand_b(operand_b),
		.float_bits(float_bits),
		.result_valid(result_valid), .result_stall(result_stall),
		.result_value(result_value), .float_result(float_result),
		.greater(greater), .less(less), .equal(equal), .range_error(range_error)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function logic [31:0] pick_operand();
		case ($urandom_range(0, 5))
			0, 1: return $urandom;
			2: return 32'($signed($urandom_range(0, 8192)) - 4096);
			3: begin
				case ($urandom_range(0, 5))
					0: return MAX_POS;
					1: return MIN_NEG;
					2: return 32'd0;
					3: return 32'hFFFF_FFFF;
					4: return 32'd1;
					default: return 32'h0000_0100;
				endcase
			end
			4: return $urandom >> $urandom_range(0, 31);
			default: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
		endcase
	endfunction

	function logic [31:0] pick_single();
		logic [7:0]  ex;
		logic [22:0] man;
		case ($urandom_range(0, 7))
			0: ex = 8'hFF;
			1: ex = 8'h00;
			2: ex = 8'($urandom);
			3: ex = 8'($urandom_range(150, 175));
			default: ex = 8'($urandom_range(100, 160));
		endcase
		case ($urandom_range(0, 3))
			0: man = 23'd0;
			1: man = 23'h40_0000 >> $urandom_range(0, 22);
			default: man = 23'($urandom);
		endcase
		return {1'($urandom), ex, man};
	endfunction

	task automatic add_item(input func_t fn, input logic [31:0] a, input logic [31:0] b,
			input logic [31:0] fb);
		alu_item_t it;
		it.fn = fn;
		it.a  = a;
		it.b  = b;
		it.fb = fb;
		stim_q.push_back(it);
	endtask

	task automatic build_stimulus();
		alu_item_t it;
		// Conversion corners, rounding ties, saturation and every operation
		add_item(FN_INT2FIX, MAX_POS, 0, 0);
		add_item(FN_INT2FIX, MIN_NEG, 0, 0);
		add_item(FN_FLOAT2FIX, 0, 0, 32'h3F00_0000);
		add_item(FN_FLOAT2FIX, 0, 0, 32'h3B00_0000);
		add_item(FN_FLOAT2FIX, 0, 0, 32'hBB00_0000);
		add_item(FN_FLOAT2FIX, 0, 0, 32'h8000_0000);
		add_item(FN_FLOAT2FIX, 0, 0, 32'h7FC0_0000);
		add_item(FN_FLOAT2FIX, 0, 0, 32'h7F80_0000);
		add_item(FN_FLOAT2FIX, 0, 0, 32'hFF80_0000);
		add_item(FN_FLOAT2FIX, 0, 0, 32'h4F00_0000);
		add_item(FN_FLOAT2FIX, 0, 0, 32'hCB00_0000);
		add_item(FN_FLOAT2FIX, 0, 0, 32'h0000_0001);
		add_item(FN_TOFLOAT, 0, 0, 0);
		add_item(FN_TOFLOAT, MAX_POS, 0, 0);
		add_item(FN_TOFLOAT, MIN_NEG, 0, 0);
		add_item(FN_TOFLOAT, 32'h0100_0001, 0, 0);
		add_item(FN_TOINT, 32'hFFFF_FF01, 0, 0);
		add_item(FN_ADD, MAX_POS, 1, 0);
		add_item(FN_SUB, MIN_NEG, 1, 0);
		add_item(FN_MUL, MIN_NEG, MIN_NEG, 0);
		add_item(FN_DIV, 32'h0000_0500, 0, 0);
		add_item(FN_DIV, MIN_NEG, 32'hFFFF_FF00, 0);
		add_item(FN_CMP, 32'h0000_0100, 32'h0000_0100, 0);
		add_item(FN_MIN, MIN_NEG, MAX_POS, 0);
		add_item(FN_MAX, MIN_NEG, MAX_POS, 0);
		add_item(FN_INC, MAX_POS, 0, 0);
		add_item(FN_DEC, MIN_NEG, 0, 0);
		it.fn = 4'd13; it.a = $urandom; it.b = $urandom; it.fb = $urandom;
		stim_q.push_back(it);
		it.fn = 4'd15;
		stim_q.push_back(it);
		// Random items, mostly defined operations
		repeat (RANDOM_ITEMS) begin
			it.fn = ($urandom_range(0, 49) == 0) ? 4'($urandom_range(13, 15))
			                                     : 4'($urandom_range(0, 12));
			it.a  = pick_operand();
			it.b  = ($urandom_range(0, 15) == 0) ? 32'd0 : pick_operand();
			it.fb = pick_single();
			stim_q.push_back(it);
		end
	endtask

	// Sender: bursts of random length, most separated by random gaps
	task automatic drive_items();
		int burst;
		burst = 0;
		foreach (stim_q[i]) begin
			if (burst == 0) begin
				burst = $urandom_range(1, 40);
				if ($urandom_range(0, 2) != 0) begin
					item_valid <= 1'b0;
					repeat ($urandom_range(1, 6)) @(posedge clk);
				end
			end
			burst--;
			item_valid <= 1'b1;
			func       <= stim_q[i].fn;
			operand_a  <= stim_q[i].a;
			operand_b  <= stim_q[i].b;
			float_bits <= stim_q[i].fb;
			@(posedge clk);
			while (item_stall)
				@(posedge clk);
			alu_sb.note_item(stim_q[i]);
		end
		item_valid <= 1'b0;
	endtask

	// Receiver: check each transfer, then pick the next stall value
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && !result_stall)
				alu_sb.check_result('{result_value, float_result, greater, less, equal,
					range_error});
			cycle_count++;
			// hold off once for a long stretch when half the items are in
			if (!hold_done &&
					2 * (alu_sb.checked + alu_sb.expected_q.size()) >= stim_q.size()) begin
				hold_done = 1'b1;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_stall <= 1'b1;
			end else
				case ((cycle_count / 97) % 4)
					0: result_stall <= 1'b0;
					1: result_stall <= ($urandom_range(0, 9) < 3);
					2: result_stall <= ($urandom_range(0, 9) < 7);
					default: result_stall <= cycle_count[0];
				endcase
		end
	end

	// Watchdog: end the run when no transfer happens for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_valid && !item_stall) || (result_valid && !result_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	initial begin
		alu_sb       = new();
		arst_n       = 1'b0;
		item_valid   = 1'b0;
		result_stall = 1'b0;
		func         = '0;
		operand_a    = '0;
		operand_b    = '0;
		float_bits   = '0;
		idle_cycles  = 0;
		cycle_count  = 0;
		hold_left    = 0;
		hold_done    = 1'b0;
		build_stimulus();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		drive_items();
		while (alu_sb.expected_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Ran %0d items over all 13 operations and unused codes; %0d results checked.",
			stim_q.size(), alu_sb.checked);
		$display("Included conversion corners, divide by zero and a long receiver hold.");
		if (alu_sb.errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
